>>> hw/rtl/range_scan_object_segmenter_macros.svh
// Assertion helpers for the checker file.
`ifndef RANGE_SCAN_OBJECT_SEGMENTER_MACROS_SVH
`define RANGE_SCAN_OBJECT_SEGMENTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define RSO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RSO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rso_pkg.sv
package rso_pkg;

    // Field widths
    localparam int DIST_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int IDX_W      = 3;
    localparam int WIDTH_W    = 8;
    localparam int ANGLE_W    = 8;
    localparam int POS_W      = 16;

    // Scan limits
    localparam int MAX_OBJECTS   = 6;
    localparam int MAX_STEPS_DEF = 128;

    // Register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IR_ENTER  = 3'd0,
        CFG_SONAR     = 3'd1,
        CFG_IR_AHEAD  = 3'd2,
        CFG_MIN_START = 3'd3,
        CFG_LARGE     = 3'd4
    } t_cfg_addr;

    // Register reset values, Q12.4 cm
    localparam logic [CFG_W-1:0] IR_ENTER_RST  = 16'd1120;
    localparam logic [CFG_W-1:0] SONAR_RST     = 16'd800;
    localparam logic [CFG_W-1:0] IR_AHEAD_RST  = 16'd1600;
    localparam logic [CFG_W-1:0] MIN_START_RST = 16'd1600;
    localparam logic [CFG_W-1:0] LARGE_RST     = 16'd112;

    typedef struct packed {
        logic [CFG_W-1:0] ir_enter_limit;
        logic [CFG_W-1:0] sonar_limit;
        logic [CFG_W-1:0] ir_lookahead_limit;
        logic [CFG_W-1:0] min_dist_start;
        logic [CFG_W-1:0] large_width_limit;
    } t_cfg;

    // Fixed-point constants
    localparam int     ARC_K_Q16    = 2286;      // 6.28/180 in Q16
    localparam int     ANG_STEP_Q16 = 1143;      // 3.14/180 in Q16
    localparam longint PI_Q16       = 205887;
    localparam longint HALF_PI_Q16  = 102944;
    localparam longint ONE_Q28      = 64'sd268435456;
    localparam int     POS_SHIFT    = 29;        // Q28 trig and r in 1/32 cm
    localparam int     ARC_RND      = 32768;
    localparam int     ARC_PROD_W   = 24;        // run width times distance

    // Shared multiplier operand widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 30;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Trig table
    localparam int TRIG_W = 30;
    localparam int TRIG_N = 1 << ANGLE_W;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef t_trig t_trig_tab [TRIG_N];

    // Q28 cosine or sine of deg*1143 Q16 radians, series about pi/2
    function automatic longint trig_q28(int deg, bit want_sin);
        longint t;
        longint u;
        longint u2;
        longint s;
        longint c;
        bit     neg;
        t   = longint'(deg) * ANG_STEP_Q16;
        neg = 1'b0;
        if (t > PI_Q16) begin
            t   = t - PI_Q16;
            neg = 1'b1;
        end
        u  = (t - HALF_PI_Q16) * 4096;
        u2 = (u * u) / ONE_Q28;
        s  = ONE_Q28 - u2 / 110;
        s  = ONE_Q28 - ((u2 * s) / ONE_Q28) / 72;
        s  = ONE_Q28 - ((u2 * s) / ONE_Q28) / 42;
        s  = ONE_Q28 - ((u2 * s) / ONE_Q28) / 20;
        s  = ONE_Q28 - ((u2 * s) / ONE_Q28) / 6;
        s  = (u * s) / ONE_Q28;
        c  = ONE_Q28 - u2 / 132;
        c  = ONE_Q28 - ((u2 * c) / ONE_Q28) / 90;
        c  = ONE_Q28 - ((u2 * c) / ONE_Q28) / 56;
        c  = ONE_Q28 - ((u2 * c) / ONE_Q28) / 30;
        c  = ONE_Q28 - ((u2 * c) / ONE_Q28) / 12;
        c  = ONE_Q28 - ((u2 * c) / ONE_Q28) / 2;
        // sin(t) = cos(u), cos(t) = -sin(u)
        if (want_sin) begin
            return neg ? -c : c;
        end
        return neg ? s : -s;
    endfunction

    // Full table, built at elaboration
    function automatic t_trig_tab build_trig_tab(bit want_sin);
        t_trig_tab tab;
        for (int i = 0; i < TRIG_N; i++) begin
            tab[i] = TRIG_W'(trig_q28(i, want_sin));
        end
        return tab;
    endfunction

    // One result request
    typedef struct packed {
        logic                    object_valid;
        logic [IDX_W-1:0]        object_index;
        logic [DIST_W-1:0]       object_distance;
        logic [ANGLE_W-1:0]      center_degrees;
        logic [DIST_W-1:0]       arc_width;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    is_large;
        logic                    scan_done;
        logic [IDX_W-1:0]        object_total;
    } t_result;

endpackage

>>> hw/rtl/rso_if.sv
// Sample request channel
interface rso_in_if import rso_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] ir_distance;
    logic [DIST_W-1:0] sonar_distance;
    logic              first_sample;
    logic              last_sample;

    modport source (output valid, ir_distance, sonar_distance, first_sample, last_sample,
                    input ready);
    modport sink   (input valid, ir_distance, sonar_distance, first_sample, last_sample,
                    output ready);
endinterface

// Result request channel
interface rso_out_if import rso_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    object_valid;
    logic [IDX_W-1:0]        object_index;
    logic [DIST_W-1:0]       object_distance;
    logic [ANGLE_W-1:0]      center_degrees;
    logic [DIST_W-1:0]       arc_width;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    is_large;
    logic                    scan_done;
    logic [IDX_W-1:0]        object_total;

    modport source (output valid, object_valid, object_index, object_distance,
                    center_degrees, arc_width, pos_x, pos_y, is_large, scan_done,
                    object_total, input ready);
    modport sink   (input valid, object_valid, object_index, object_distance,
                    center_degrees, arc_width, pos_x, pos_y, is_large, scan_done,
                    object_total, output ready);
endinterface

// Register write channel
interface rso_cfg_if import rso_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] reg_index;
    logic [CFG_W-1:0]      wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> hw/rtl/rso_cfg_regs.sv
module rso_cfg_regs import rso_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rso_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    // Writes never stall
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ir_enter_limit     <= IR_ENTER_RST;
            r_cfg.sonar_limit        <= SONAR_RST;
            r_cfg.ir_lookahead_limit <= IR_AHEAD_RST;
            r_cfg.min_dist_start     <= MIN_START_RST;
            r_cfg.large_width_limit  <= LARGE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_addr'(i_cfg.reg_index))
                CFG_IR_ENTER:  r_cfg.ir_enter_limit     <= i_cfg.wdata;
                CFG_SONAR:     r_cfg.sonar_limit        <= i_cfg.wdata;
                CFG_IR_AHEAD:  r_cfg.ir_lookahead_limit <= i_cfg.wdata;
                CFG_MIN_START: r_cfg.min_dist_start     <= i_cfg.wdata;
                CFG_LARGE:     r_cfg.large_width_limit  <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/rso_trig_rom.sv
module rso_trig_rom import rso_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [ANGLE_W-1:0] i_angle,
    output t_trig              o_cos,
    output t_trig              o_sin
);

    localparam t_trig_tab COS_TAB = build_trig_tab(1'b0);
    localparam t_trig_tab SIN_TAB = build_trig_tab(1'b1);

    t_trig r_cos;
    t_trig r_sin;

    // Registered lookup, one angle per request
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= COS_TAB[i_angle];
            r_sin <= SIN_TAB[i_angle];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> hw/rtl/rso_mul_unit.sv
module rso_mul_unit import rso_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    // Signed multiply, product held until the next enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/range_scan_object_segmenter.sv
// Range-scan object segmenter. Each sample request (IR and sonar range, Q12.4 cm, one per
// 2-degree step) is held back one step and judged against the next sample; runs of close
// samples form objects, and an object is reported when the run ends: minimum sonar
// distance, centre angle, arc width, x/y and a large flag. A sample that gives no result
// leaves the input ready. A last-sample request with no object closing goes straight to
// the output state. An object close sends four products through the one shared
// multiplier (width x distance, x arc constant, x cosine, x sine), with a registered
// cosine/sine table lookup alongside; the input is not ready meanwhile.
// A finished result waits in the output register while the next sample is taken.
// There is no clearing pass after reset.
module range_scan_object_segmenter import rso_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rso_in_if.sink     i_sample,
    rso_out_if.source  o_result,
    rso_cfg_if.sink    i_cfg
);

    localparam int STEP_W = $clog2(MAX_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_W,
        S_MUL_K,
        S_ARC,
        S_MUL_X,
        S_MUL_Y,
        S_OUT
    } t_state;

    t_cfg cfg;

    // Sequencer and scan state
    t_state              r_state;
    logic [DIST_W-1:0]   r_held_ir;
    logic [DIST_W-1:0]   r_held_sonar;
    logic                r_present;
    logic [STEP_W-1:0]   r_step;
    logic                r_in_obj;
    logic [WIDTH_W-1:0]  r_width;
    logic [DIST_W-1:0]   r_min;
    logic [IDX_W-1:0]    r_found;

    // Object being closed
    logic [DIST_W-1:0]   r_e_dist;
    logic [ANGLE_W-1:0]  r_e_ctr;
    logic [WIDTH_W-1:0]  r_e_width;
    logic [IDX_W-1:0]    r_e_idx;
    logic                r_obj;
    logic                r_done;
    logic [IDX_W-1:0]    r_total;
    logic [DIST_W-1:0]   r_arc;
    logic [POS_W-1:0]    r_x;

    // Output register
    t_result             r_res;
    logic                r_out_valid;

    // Next scan state
    logic [DIST_W-1:0]   n_held_ir;
    logic [DIST_W-1:0]   n_held_sonar;
    logic                n_present;
    logic [STEP_W-1:0]   n_step;
    logic                n_in_obj;
    logic [WIDTH_W-1:0]  n_width;
    logic [DIST_W-1:0]   n_min;
    logic [IDX_W-1:0]    n_found;
    logic                n_leave;
    logic [ANGLE_W-1:0]  n_ctr;

    logic                in_acc;
    logic                close_ir;
    logic                close_so;
    logic                in_obj_v;
    logic signed [9:0]   twice_step;
    logic signed [9:0]   ctr_full;

    // Datapath
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    t_trig                     trig_cos;
    t_trig                     trig_sin;
    logic [MUL_P_W-1:0]        arc_sum;
    logic [DIST_W-1:0]         arc_sat;
    logic [17:0]               rad;

    rso_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rso_trig_rom u_trig (
        .i_clk   (i_clk),
        .i_en    (r_state == S_MUL_W),
        .i_angle (r_e_ctr),
        .o_cos   (trig_cos),
        .o_sin   (trig_sin)
    );

    rso_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Q33 product to Q11.4: divide by 2^29 toward zero, then saturate
    function automatic logic [POS_W-1:0] pos_sat(logic signed [MUL_P_W-1:0] p);
        logic signed [MUL_P_W-1:0] adj;
        logic signed [MUL_P_W-1:0] q;
        adj = p;
        if (p[MUL_P_W-1]) begin
            adj = p + $signed(MUL_P_W'((64'd1 << POS_SHIFT) - 64'd1));
        end
        q = adj >>> POS_SHIFT;
        if (q > $signed(MUL_P_W'(32767))) begin
            return 16'h7FFF;
        end else if (q < $signed(-MUL_P_W'(32768))) begin
            return 16'h8000;
        end
        return q[POS_W-1:0];
    endfunction

    assign in_acc         = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);

    // Judge the held sample against the incoming one
    assign close_ir   = r_held_ir < cfg.ir_enter_limit;
    assign close_so   = r_held_sonar < cfg.sonar_limit;
    assign in_obj_v   = r_in_obj || (close_ir && close_so &&
                        (i_sample.ir_distance < cfg.ir_lookahead_limit) &&
                        (i_sample.sonar_distance != '0));
    assign twice_step = $signed({{(9 - STEP_W){1'b0}}, r_step, 1'b0});
    assign ctr_full   = twice_step - $signed({2'b00, r_width});

    always_comb begin
        n_held_ir    = r_held_ir;
        n_held_sonar = r_held_sonar;
        n_present    = r_present;
        n_step       = r_step;
        n_in_obj     = r_in_obj;
        n_width      = r_width;
        n_min        = r_min;
        n_found      = r_found;
        n_leave      = 1'b0;
        if (ctr_full < 10'sd0) begin
            n_ctr = '0;
        end else if (ctr_full > 10'sd255) begin
            n_ctr = '1;
        end else begin
            n_ctr = ctr_full[ANGLE_W-1:0];
        end

        if (i_sample.first_sample || !r_present) begin
            // New scan: take the sample as held, judge nothing
            n_step       = '0;
            n_found      = '0;
            n_in_obj     = 1'b0;
            n_width      = '0;
            n_min        = cfg.min_dist_start;
            n_held_ir    = i_sample.ir_distance;
            n_held_sonar = i_sample.sonar_distance;
            n_present    = 1'b1;
        end else if (r_step < STEP_W'(MAX_STEPS - 1)) begin
            if (r_found < IDX_W'(MAX_OBJECTS)) begin
                if (in_obj_v && !(close_ir && close_so)) begin
                    // Run ended
                    n_leave  = 1'b1;
                    n_found  = r_found + 1'b1;
                    n_in_obj = 1'b0;
                    n_width  = '0;
                    n_min    = cfg.min_dist_start;
                end else if (in_obj_v) begin
                    n_in_obj = 1'b1;
                    if (r_width != '1) begin
                        n_width = r_width + 1'b1;
                    end
                    if (r_held_sonar < r_min) begin
                        n_min = r_held_sonar;
                    end
                end
            end
            n_held_ir    = i_sample.ir_distance;
            n_held_sonar = i_sample.sonar_distance;
            n_step       = r_step + 1'b1;
        end

        if (i_sample.last_sample) begin
            // End of scan drops any open run
            n_present = 1'b0;
            n_in_obj  = 1'b0;
            n_width   = '0;
            n_min     = cfg.min_dist_start;
        end
    end

    // Arc width: round the Q16 product, saturate to 16 bits
    assign arc_sum = $unsigned(prod) + MUL_P_W'(ARC_RND);
    assign arc_sat = (|arc_sum[MUL_P_W-1:32]) ? '1 : arc_sum[31:16];
    // Radius in 1/32 cm: twice the distance plus the arc width
    assign rad     = {1'b0, r_e_dist, 1'b0} + {2'b00, r_arc};

    // Operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MUL_W: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(r_e_width);
                mul_b  = MUL_B_W'(r_e_dist);
            end
            S_MUL_K: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(prod[ARC_PROD_W-1:0]);
                mul_b  = MUL_B_W'(ARC_K_Q16);
            end
            S_MUL_X: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(rad);
                mul_b  = trig_cos;
            end
            S_MUL_Y: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(rad);
                mul_b  = trig_sin;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, scan state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= 1'b0;
            r_step      <= '0;
            r_in_obj    <= 1'b0;
            r_width     <= '0;
            r_min       <= MIN_START_RST;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_held_ir    <= n_held_ir;
                        r_held_sonar <= n_held_sonar;
                        r_present    <= n_present;
                        r_step       <= n_step;
                        r_in_obj     <= n_in_obj;
                        r_width      <= n_width;
                        r_min        <= n_min;
                        r_found      <= n_found;
                        r_obj        <= n_leave;
                        r_done       <= i_sample.last_sample;
                        r_total      <= n_found;
                        r_e_dist     <= r_min;
                        r_e_ctr      <= n_ctr;
                        r_e_width    <= r_width;
                        r_e_idx      <= r_found;
                        if (n_leave) begin
                            r_state <= S_MUL_W;
                        end else if (i_sample.last_sample) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MUL_W: begin
                    r_state <= S_MUL_K;
                end
                S_MUL_K: begin
                    r_state <= S_ARC;
                end
                S_ARC: begin
                    r_arc   <= arc_sat;
                    r_state <= S_MUL_X;
                end
                S_MUL_X: begin
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_x     <= pos_sat(prod);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_res.scan_done    <= r_done;
                        r_res.object_total <= r_total;
                        if (r_obj) begin
                            r_res.object_valid    <= 1'b1;
                            r_res.object_index    <= r_e_idx;
                            r_res.object_distance <= r_e_dist;
                            r_res.center_degrees  <= r_e_ctr;
                            r_res.arc_width       <= r_arc;
                            r_res.pos_x           <= r_x;
                            r_res.pos_y           <= pos_sat(prod);
                            r_res.is_large        <= (r_arc >= cfg.large_width_limit);
                        end else begin
                            r_res.object_valid    <= 1'b0;
                            r_res.object_index    <= '0;
                            r_res.object_distance <= '0;
                            r_res.center_degrees  <= '0;
                            r_res.arc_width       <= '0;
                            r_res.pos_x           <= '0;
                            r_res.pos_y           <= '0;
                            r_res.is_large        <= 1'b0;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result channel
    assign o_result.valid           = r_out_valid;
    assign o_result.object_valid    = r_res.object_valid;
    assign o_result.object_index    = r_res.object_index;
    assign o_result.object_distance = r_res.object_distance;
    assign o_result.center_degrees  = r_res.center_degrees;
    assign o_result.arc_width       = r_res.arc_width;
    assign o_result.pos_x           = r_res.pos_x;
    assign o_result.pos_y           = r_res.pos_y;
    assign o_result.is_large        = r_res.is_large;
    assign o_result.scan_done       = r_res.scan_done;
    assign o_result.object_total    = r_res.object_total;

endmodule

>>> hw/rtl/rso_checker.sv
`include "range_scan_object_segmenter_macros.svh"

module rso_checker import rso_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic                    i_object_valid,
    input logic [IDX_W-1:0]        i_object_index,
    input logic [DIST_W-1:0]       i_object_distance,
    input logic [ANGLE_W-1:0]      i_center_degrees,
    input logic [DIST_W-1:0]       i_arc_width,
    input logic signed [POS_W-1:0] i_pos_x,
    input logic signed [POS_W-1:0] i_pos_y,
    input logic                    i_is_large,
    input logic                    i_scan_done,
    input logic [IDX_W-1:0]        i_object_total
);

    // A stalled result request holds
    `RSO_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_object_index) && $stable(i_object_distance) && $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_scan_done) && $stable(i_object_total), "result changed while stalled")

    // A closed object is counted in the running total
    `RSO_ASSERT_IMP(a_total_idx, i_clk, i_rst_n, i_out_valid && i_object_valid, i_object_total == i_object_index + 3'd1, "object total does not follow index")

    // A result without an object is an end of scan with cleared fields
    `RSO_ASSERT_IMP(a_done_only, i_clk, i_rst_n, i_out_valid && !i_object_valid, i_scan_done && (i_object_distance == '0) && (i_arc_width == '0) && (i_center_degrees == '0) && (i_pos_x == '0) && (i_pos_y == '0) && !i_is_large, "empty result not cleared")

    // Never more objects than the scan allows
    `RSO_ASSERT_IMP(a_total_max, i_clk, i_rst_n, i_out_valid, i_object_total <= IDX_W'(MAX_OBJECTS), "object total above limit")

endmodule

bind range_scan_object_segmenter rso_checker u_rso_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_object_valid    (o_result.object_valid),
    .i_object_index    (o_result.object_index),
    .i_object_distance (o_result.object_distance),
    .i_center_degrees  (o_result.center_degrees),
    .i_arc_width       (o_result.arc_width),
    .i_pos_x           (o_result.pos_x),
    .i_pos_y           (o_result.pos_y),
    .i_is_large        (o_result.is_large),
    .i_scan_done       (o_result.scan_done),
    .i_object_total    (o_result.object_total)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb import rso_pkg::*; ();

    localparam int     SETTLE_CYCLES = 20;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     PHASE_ITEMS   = 42;
    localparam longint ARC_GAIN      = 2286;    // 2 degrees in radians, Q16
    localparam longint DEG_STEP      = 1143;    // 1 degree in radians, Q16
    localparam longint PI_Q16_L      = 205887;
    localparam longint HALF_PI_Q16_L = 102944;
    localparam longint UNIT          = 64'sd268435456;   // 1.0 in Q28
    localparam longint POS_DIV       = 64'sd536870912;   // Q28 trig times 1/32 cm

    localparam t_cfg RESET_LIMITS = '{IR_ENTER_RST, SONAR_RST, IR_AHEAD_RST,
                                      MIN_START_RST, LARGE_RST};

    typedef struct packed {
        logic [DIST_W-1:0] ir;
        logic [DIST_W-1:0] sonar;
        logic              first;
        logic              last;
    } t_scan_sample;

    logic clk;
    logic rst_n;

    rso_in_if  sample_bus ();
    rso_out_if result_bus ();
    rso_cfg_if cfg_bus ();

    range_scan_object_segmenter dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // Segmenter state as the testbench tracks it
    t_cfg              limits     = RESET_LIMITS;
    logic [DIST_W-1:0] held_ir    = '0;
    logic [DIST_W-1:0] held_sonar = '0;
    bit                held_valid = 1'b0;
    int                held_step  = 0;
    bit                in_run     = 1'b0;
    int                run_len    = 0;
    logic [DIST_W-1:0] run_min    = MIN_START_RST;
    int                objs       = 0;

    // Thresholds the stimulus is shaped around
    t_cfg scan_cfg = RESET_LIMITS;

    t_scan_sample samples_to_send[$];
    t_result      reports_due[$];
    t_scan_sample in_flight;
    int           n_queued     = 0;
    int           n_accepted   = 0;
    int           errors       = 0;
    int           gap_left     = 0;
    int           hold_left    = 0;
    bit           sender_calm  = 1'b0;
    bit           receiver_calm = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic log_error(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // Q28 cosine and sine of deg degrees, Taylor series about pi/2
    function automatic void angle_q28(int deg, output longint cs, output longint sn);
        longint t;
        longint u;
        longint u2;
        longint s;
        longint c;
        bit     flip;
        t    = longint'(deg) * DEG_STEP;
        flip = t > PI_Q16_L;
        if (flip) t = t - PI_Q16_L;
        u  = (t - HALF_PI_Q16_L) * 4096;
        u2 = (u * u) / UNIT;
        s  = UNIT;
        c  = UNIT;
        // nested Horner terms: sine odd factorial pairs, cosine even ones
        for (int n = 5; n >= 1; n--) s = UNIT - ((u2 * s) / UNIT) / (2 * n * (2 * n + 1));
        for (int n = 6; n >= 1; n--) c = UNIT - ((u2 * c) / UNIT) / ((2 * n - 1) * 2 * n);
        s  = (u * s) / UNIT;
        sn = flip ? -c : c;
        cs = flip ? s : -s;
    endfunction

    function automatic logic signed [POS_W-1:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[POS_W-1:0];
    endfunction

    function automatic void restart_run();
        in_run  = 1'b0;
        run_len = 0;
        run_min = limits.min_dist_start;
    endfunction

    // Advance the tracked state by one accepted sample request
    function automatic void segment_step(t_scan_sample smp);
        t_result r;
        bit      emit;
        bit      near_ir;
        bit      near_so;
        int      ctr;
        longint  arc;
        longint  rad;
        longint  cs;
        longint  sn;
        r    = '0;
        emit = 1'b0;
        if (smp.first) held_valid = 1'b0;
        if (!held_valid) begin
            held_step  = 0;
            objs       = 0;
            restart_run();
            held_ir    = smp.ir;
            held_sonar = smp.sonar;
            held_valid = 1'b1;
        end else if (held_step < MAX_STEPS_DEF - 1) begin
            if (objs < MAX_OBJECTS) begin
                near_ir = held_ir < limits.ir_enter_limit;
                near_so = held_sonar < limits.sonar_limit;
                if (!in_run && near_ir && near_so && smp.ir < limits.ir_lookahead_limit
                        && smp.sonar != 0)
                    in_run = 1'b1;
                // run ends: close the object
                if (in_run && !(near_ir && near_so)) begin
                    ctr = 2 * held_step - run_len;
                    if (ctr < 0) ctr = 0;
                    if (ctr > 255) ctr = 255;
                    arc = (longint'(run_len) * longint'(run_min) * ARC_GAIN + 32768) >>> 16;
                    if (arc > 65535) arc = 65535;
                    angle_q28(ctr, cs, sn);
                    rad = 2 * longint'(run_min) + arc;
                    r.object_valid    = 1'b1;
                    r.object_index    = objs[IDX_W-1:0];
                    r.object_distance = run_min;
                    r.center_degrees  = ctr[ANGLE_W-1:0];
                    r.arc_width       = arc[DIST_W-1:0];
                    r.pos_x           = clip16((rad * cs) / POS_DIV);
                    r.pos_y           = clip16((rad * sn) / POS_DIV);
                    r.is_large        = arc >= longint'(limits.large_width_limit);
                    objs++;
                    emit = 1'b1;
                    restart_run();
                end
                if (in_run) begin
                    if (run_len < 255) run_len++;
                    if (held_sonar < run_min) run_min = held_sonar;
                end
            end
            held_ir    = smp.ir;
            held_sonar = smp.sonar;
            held_step++;
        end
        if (smp.last) begin
            r.scan_done = 1'b1;
            emit        = 1'b1;
            held_valid  = 1'b0;
            restart_run();
        end
        r.object_total = objs[IDX_W-1:0];
        if (emit) reports_due.push_back(r);
    endfunction

    // Idle stretch length: mostly short, a few long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if ($urandom_range(0, 24) == 0) sender_calm = !sender_calm;
        if (sender_calm || $urandom_range(0, 99) < 55) return 0;
        return idle_len();
    endfunction

    // Sample request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            sample_bus.valid          <= 1'b0;
            sample_bus.ir_distance    <= '0;
            sample_bus.sonar_distance <= '0;
            sample_bus.first_sample   <= 1'b0;
            sample_bus.last_sample    <= 1'b0;
            gap_left = 0;
        end else begin
            if (sample_bus.valid && sample_bus.ready) begin
                segment_step(in_flight);
                n_accepted++;
            end
            if (!sample_bus.valid || sample_bus.ready) begin
                if (gap_left > 0 || samples_to_send.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    sample_bus.valid <= 1'b0;
                end else begin
                    in_flight = samples_to_send.pop_front();
                    sample_bus.ir_distance    <= in_flight.ir;
                    sample_bus.sonar_distance <= in_flight.sonar;
                    sample_bus.first_sample   <= in_flight.first;
                    sample_bus.last_sample    <= in_flight.last;
                    sample_bus.valid          <= 1'b1;
                    gap_left = sender_gap();
                end
            end
        end
    end

    task automatic same(string name, logic signed [31:0] got, logic signed [31:0] want);
        if (got !== want) log_error($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_result();
        t_result want;
        if (reports_due.size() == 0) begin
            log_error("result request with no result pending");
        end else begin
            want = reports_due.pop_front();
            same("object_valid", result_bus.object_valid, want.object_valid);
            same("object_index", result_bus.object_index, want.object_index);
            same("object_distance", result_bus.object_distance, want.object_distance);
            same("center_degrees", result_bus.center_degrees, want.center_degrees);
            same("arc_width", result_bus.arc_width, want.arc_width);
            same("pos_x", result_bus.pos_x, want.pos_x);
            same("pos_y", result_bus.pos_y, want.pos_y);
            same("is_large", result_bus.is_large, want.is_large);
            same("scan_done", result_bus.scan_done, want.scan_done);
            same("object_total", result_bus.object_total, want.object_total);
        end
    endtask

    // Result monitor with random back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) check_result();
            if ($urandom_range(0, 199) == 0) receiver_calm = !receiver_calm;
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
                if (!receiver_calm && $urandom_range(0, 3) == 0) hold_left = idle_len();
            end
        end
    end

    task automatic push_sample(logic [DIST_W-1:0] ir, logic [DIST_W-1:0] sonar,
                               bit first, bit last);
        t_scan_sample s;
        s.ir    = ir;
        s.sonar = sonar;
        s.first = first;
        s.last  = last;
        samples_to_send.push_back(s);
        n_queued++;
    endtask

    // One scan of alternating close and far runs with random content
    task automatic queue_scan(int len, bit open_scan, bit close_scan);
        logic [DIST_W-1:0] ir;
        logic [DIST_W-1:0] sonar;
        int                ir_top;
        int                sonar_floor;
        int                run_left;
        bit                near;
        near     = 1'b0;
        run_left = 0;
        ir_top   = (scan_cfg.ir_enter_limit < scan_cfg.ir_lookahead_limit) ?
                   scan_cfg.ir_enter_limit : scan_cfg.ir_lookahead_limit;
        // a high floor keeps the run minimum up so the arc can saturate
        sonar_floor = ($urandom_range(0, 1) == 0) ? 1 : scan_cfg.sonar_limit / 2;
        if (sonar_floor < 1) sonar_floor = 1;
        for (int i = 0; i < len; i++) begin
            if (run_left == 0) begin
                near = !near;
                if (!near) run_left = $urandom_range(1, 4);
                else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(20, 60);
                else run_left = $urandom_range(1, 8);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                ir    = $urandom;
                sonar = $urandom;
            end else if (near) begin
                ir    = (ir_top > 0) ? $urandom_range(0, ir_top - 1) : '0;
                sonar = (scan_cfg.sonar_limit > 1 && $urandom_range(0, 11) != 0) ?
                        $urandom_range(sonar_floor, scan_cfg.sonar_limit - 1) : '0;
            end else if ($urandom_range(0, 1) == 0) begin
                ir    = $urandom_range(scan_cfg.ir_enter_limit, 16'hffff);
                sonar = $urandom;
            end else begin
                ir    = $urandom;
                sonar = $urandom_range(scan_cfg.sonar_limit, 16'hffff);
            end
            push_sample(ir, sonar, open_scan && i == 0, close_scan && i == len - 1);
        end
    endtask

    task automatic queue_random(int n);
        int mark;
        int len;
        mark = n_queued;
        while (n_queued - mark < n) begin
            // last scan of the phase is cut to fit
            len = $urandom_range(1, 30);
            if (len > n - (n_queued - mark)) len = n - (n_queued - mark);
            queue_scan(len, $urandom_range(0, 4) != 0, $urandom_range(0, 5) != 0);
        end
    endtask

    task automatic settle();
        while (n_accepted != n_queued || reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_addr idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wdata     <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_IR_ENTER:  limits.ir_enter_limit     = val;
            CFG_SONAR:     limits.sonar_limit        = val;
            CFG_IR_AHEAD:  limits.ir_lookahead_limit = val;
            CFG_MIN_START: limits.min_dist_start     = val;
            CFG_LARGE:     limits.large_width_limit  = val;
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic load_limits(t_cfg c);
        write_reg(CFG_IR_ENTER, c.ir_enter_limit);
        write_reg(CFG_SONAR, c.sonar_limit);
        write_reg(CFG_IR_AHEAD, c.ir_lookahead_limit);
        write_reg(CFG_MIN_START, c.min_dist_start);
        write_reg(CFG_LARGE, c.large_width_limit);
    endtask

    // Ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("range_scan_object_segmenter regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_cfg setting;
        rst_n             = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.reg_index = CFG_IR_ENTER;
        cfg_bus.wdata     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Zero sonar ahead blocks entry, object closes, open object dropped at scan end
        push_sample(16'd0, 16'd0, 1'b1, 1'b0);
        push_sample(16'd500, 16'd0, 1'b0, 1'b0);
        push_sample(16'd500, 16'd300, 1'b0, 1'b0);
        push_sample(16'hffff, 16'hffff, 1'b0, 1'b0);
        push_sample(16'd400, 16'd200, 1'b0, 1'b0);
        push_sample(16'd400, 16'd250, 1'b0, 1'b0);
        push_sample(16'd100, 16'd100, 1'b0, 1'b1);
        // Seven one-step objects: only six are reported
        push_sample(16'd500, 16'd300, 1'b1, 1'b0);
        for (int k = 0; k < 7; k++) begin
            push_sample(16'd1200, 16'd900, 1'b0, 1'b0);
            push_sample(16'd500, 16'd300, 1'b0, k == 6);
        end
        // First sample mid-scan, then a scan of a single sample
        push_sample(16'hffff, 16'hffff, 1'b1, 1'b0);
        push_sample(16'h8000, 16'h0001, 1'b1, 1'b1);
        // Long scan: an object closes just below the step limit, one past it is ignored
        push_sample(16'd1200, 16'd900, 1'b1, 1'b0);
        for (int k = 1; k <= 124; k++) push_sample(16'd1200, 16'd900, 1'b0, 1'b0);
        push_sample(16'd500, 16'd300, 1'b0, 1'b0);
        push_sample(16'd1200, 16'd900, 1'b0, 1'b0);
        push_sample(16'd500, 16'd300, 1'b0, 1'b0);
        push_sample(16'd1200, 16'd900, 1'b0, 1'b0);
        push_sample(16'd500, 16'd300, 1'b0, 1'b0);
        push_sample(16'd1200, 16'd900, 1'b0, 1'b1);
        queue_random(PHASE_ITEMS);

        // Threshold settings, extremes among them
        for (int p = 1; p <= 6; p++) begin
            case (p)
                1: setting = '0;
                2: setting = '1;
                3: setting = '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 65535)), 16'($urandom),
                               16'($urandom_range(0, 3000))};
                4: setting = '{16'd2, 16'd2, 16'd4, 16'd0, 16'd0};
                5: setting = '{16'd20000, 16'd30000, 16'd40000, 16'd50000, 16'd500};
                default: setting = RESET_LIMITS;
            endcase
            settle();
            load_limits(setting);
            scan_cfg = setting;
            queue_random(PHASE_ITEMS);
        end

        settle();
        if (errors == 0 && reports_due.size() == 0) begin
            $display("range_scan_object_segmenter regression: pass");
        end else begin
            $display("range_scan_object_segmenter regression: fail");
        end
        $finish;
    end

endmodule

>>> range_scan_object_segmenter.f
+incdir+hw/rtl
hw/rtl/rso_pkg.sv
hw/rtl/rso_if.sv
hw/rtl/rso_cfg_regs.sv
hw/rtl/rso_trig_rom.sv
hw/rtl/rso_mul_unit.sv
hw/rtl/range_scan_object_segmenter.sv
hw/rtl/rso_checker.sv
tb/tb.sv
